FILE: rtl/scd_pkg.sv
// shared types, constants and a helper function for the serial servo command decoder
`timescale 1ns / 1ps
`default_nettype none
package scd_pkg;

    // result status codes
    localparam logic [1:0] ST_DIGIT    = 2'd0;
    localparam logic [1:0] ST_SERVO    = 2'd1;
    localparam logic [1:0] ST_SEQUENCE = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    // received byte codes
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;
    localparam logic [7:0] CHAR_A    = 8'd97;
    localparam logic [7:0] CHAR_F    = 8'd102;
    localparam logic [7:0] CHAR_SEQ  = 8'd103;

    localparam int         ACCUM_WIDTH_DEF = 16;
    localparam logic [7:0] ANGLE_MAX       = 8'd180;
    localparam logic [8:0] OFF_BASE        = 9'd110;

    // off count = 110 + 2*a + floor(116*a/1000)
    // floor(116*a/1000) = floor(29*a/250) = (a * 29 * ceil(2^24/250)) >> 24, exact for a <= 180
    localparam int          OFF_RECIP_SHIFT = 24;
    localparam logic [20:0] OFF_RECIP       = 21'd1946161;
    localparam int          OFF_PROD_WIDTH  = 29;

    // last member sits in the lowest bits, so status lands in tdata[1:0]
    typedef struct packed {
        logic [8:0] off_count;
        logic [7:0] angle_value;
        logic [3:0] pwm_channel;
        logic [2:0] servo_index;
        logic [1:0] status;
    } t_scd_res;

    localparam int RES_WIDTH   = $bits(t_scd_res);
    localparam int TDATA_WIDTH = ((RES_WIDTH + 7) / 8) * 8;

    // expander channel of each servo
    function automatic logic [3:0] servo_channel(input logic [2:0] idx);
        logic [3:0] ch;
        case (idx)
            3'd0:    ch = 4'd0;
            3'd1:    ch = 4'd1;
            3'd2:    ch = 4'd2;
            3'd3:    ch = 4'd9;
            3'd4:    ch = 4'd11;
            3'd5:    ch = 4'd10;
            default: ch = 4'd0;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/serial_servo_command_decoder.sv
// top level of the serial servo command decoder: input register, decode, result register
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid/tready      tdata[25:0] status, servo_index, pwm_channel,
//                                           angle_value, off_count
//
// one word accepted per cycle while the result stage is not stalled
// each word goes through the input register, the decode, then the result register
// synchronous active-low reset clears the valid flags and the accumulator
// a stalled result holds; the input register keeps filling until both stages are full
// servo angles are reported in the result word clamped to ANGLE_MAX
`timescale 1ns / 1ps
`default_nettype none
module serial_servo_command_decoder #(
    parameter int ACCUM_WIDTH = scd_pkg::ACCUM_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave side
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
    // master side
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [1:0] status, [4:2] servo_index, [8:5] pwm_channel, [16:9] angle_value,
    // [25:17] off_count, [31:26] zero
    output logic [scd_pkg::TDATA_WIDTH-1:0]      m_axis_tdata
);
    import scd_pkg::*;

    // input stage
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    // running decimal number
    logic [ACCUM_WIDTH-1:0] r_acc;
    logic [ACCUM_WIDTH-1:0] n_acc;
    // result stage
    logic                   r_out_valid;
    t_scd_res               r_out_res;
    t_scd_res               n_out_res;

    logic                   advance;
    logic                   in_take;

    // input word moves to the result stage when that stage is empty or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    scd_decode #(
        .ACCUM_WIDTH(ACCUM_WIDTH)
    ) u_decode (
        .i_byte (r_in_byte),
        .i_acc  (r_acc),
        .o_acc  (n_acc),
        .o_res  (n_out_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // accumulator follows the words in order as they leave the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (advance) begin
            r_acc <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= n_out_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_WIDTH'(r_out_res);

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !advance)
        else $error("result overwritten while stalled");

    // a servo or sequence word leaves the accumulator cleared
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_out_res.status == ST_SERVO || n_out_res.status == ST_SEQUENCE))
        |=> (r_acc == '0))
        else $error("accumulator not cleared after letter");

    // stored angle stays in range, off count is at least its base and servo index is valid
    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.status == ST_SERVO)
        |-> (r_out_res.angle_value <= ANGLE_MAX && r_out_res.off_count >= OFF_BASE
             && r_out_res.servo_index <= 3'd5))
        else $error("servo result out of range");

    // non-servo results carry zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.status != ST_SERVO)
        |-> (r_out_res.servo_index == '0 && r_out_res.pwm_channel == '0
             && r_out_res.angle_value == '0 && r_out_res.off_count == '0))
        else $error("non-servo result has nonzero fields");

    // a taken result with nothing behind it empties the result stage
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tready && !advance) |=> !r_out_valid)
        else $error("result stage did not drain");

endmodule
`default_nettype wire

FILE: rtl/scd_decode.sv
// byte classifier, accumulator update and servo off count for one received word
`timescale 1ns / 1ps
`default_nettype none
module scd_decode #(
    parameter int ACCUM_WIDTH = scd_pkg::ACCUM_WIDTH_DEF
) (
    input  wire logic [7:0]             i_byte,
    input  wire logic [ACCUM_WIDTH-1:0] i_acc,
    output logic      [ACCUM_WIDTH-1:0] o_acc,
    output scd_pkg::t_scd_res           o_res
);
    import scd_pkg::*;

    logic                      is_digit;
    logic                      is_letter;
    logic [3:0]                digit;
    logic [7:0]                letter_off;
    logic [7:0]                angle;
    logic [OFF_PROD_WIDTH-1:0] frac_prod;
    logic [ACCUM_WIDTH-1:0]    acc_times_ten;

    assign is_digit   = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign is_letter  = (i_byte >= CHAR_A) && (i_byte <= CHAR_F);
    assign digit      = 4'(i_byte - CHAR_ZERO);
    assign letter_off = i_byte - CHAR_A;

    // acc*10 as two shifts, wraps at the accumulator width
    assign acc_times_ten = (i_acc << 3) + (i_acc << 1);

    // clamp to the servo range
    assign angle = (i_acc > ACCUM_WIDTH'(ANGLE_MAX)) ? ANGLE_MAX : i_acc[7:0];

    assign frac_prod = OFF_PROD_WIDTH'(angle) * OFF_PROD_WIDTH'(OFF_RECIP);

    always_comb begin
        o_acc = i_acc;
        o_res = '0;
        if (is_digit) begin
            o_acc        = acc_times_ten + ACCUM_WIDTH'(digit);
            o_res.status = ST_DIGIT;
        end else if (is_letter) begin
            o_acc             = '0;
            o_res.status      = ST_SERVO;
            o_res.servo_index = letter_off[2:0];
            o_res.pwm_channel = servo_channel(letter_off[2:0]);
            o_res.angle_value = angle;
            o_res.off_count   = OFF_BASE + {angle, 1'b0}
                                + 9'(frac_prod[OFF_PROD_WIDTH-1:OFF_RECIP_SHIFT]);
        end else if (i_byte == CHAR_SEQ) begin
            o_acc        = '0;
            o_res.status = ST_SEQUENCE;
        end else begin
            o_res.status = ST_BAD;
        end
    end

endmodule
`default_nettype wire

FILE: tb/serial_servo_command_decoder_test.sv
// self-checking testbench for the serial servo command decoder
`timescale 1ns / 1ps
`default_nettype none
module serial_servo_command_decoder_test;
    import scd_pkg::*;

    localparam int ACCUM_BITS   = ACCUM_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 400;
    localparam int DRAIN_CYCLES = 10;

    // one decoded result as it is expected on the master side
    typedef struct {
        logic [1:0] status;
        logic [2:0] servo_index;
        logic [3:0] pwm_channel;
        logic [7:0] angle_value;
        logic [8:0] off_count;
    } t_servo_result;

    // keeps its own copy of the decoder state and the results still due
    class servo_decode_scoreboard;
        logic [ACCUM_BITS-1:0] digit_total;
        logic [7:0]            servo_angle [6];
        logic [3:0]            channel_of  [6];
        t_servo_result         results_due [$];
        int                    failures;

        function new();
            digit_total = '0;
            foreach (servo_angle[k]) servo_angle[k] = 8'd90;
            channel_of = '{4'd0, 4'd1, 4'd2, 4'd9, 4'd11, 4'd10};
            failures = 0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // work out the result of one accepted byte
        function void note_byte(input logic [7:0] rx);
            t_servo_result r;
            int            k;
            int            clamped;
            r = '{ST_BAD, 3'd0, 4'd0, 8'd0, 9'd0};
            if (rx >= CHAR_ZERO && rx <= CHAR_NINE) begin
                digit_total = ACCUM_BITS'(digit_total * 10 + int'(rx - CHAR_ZERO));
                r.status = ST_DIGIT;
            end else if (rx >= CHAR_A && rx <= CHAR_F) begin
                k = int'(rx - CHAR_A);
                clamped = (digit_total > ANGLE_MAX) ? int'(ANGLE_MAX) : int'(digit_total);
                servo_angle[k] = clamped[7:0];
                digit_total = '0;
                r.status = ST_SERVO;
                r.servo_index = k[2:0];
                r.pwm_channel = channel_of[k];
                r.angle_value = clamped[7:0];
                r.off_count = 9'(int'(OFF_BASE) + (2116 * clamped) / 1000);
            end else if (rx == CHAR_SEQ) begin
                digit_total = '0;
                r.status = ST_SEQUENCE;
            end
            results_due.push_back(r);
        endfunction

        // compare one result word with the oldest expected result
        function void check_word(input logic [TDATA_WIDTH-1:0] word);
            t_servo_result e;
            if (results_due.size() == 0) begin
                $error("result word %h with no result expected", word);
                failures++;
                return;
            end
            e = results_due.pop_front();
            if (word[1:0] !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, word[1:0]);
                failures++;
            end
            if (word[4:2] !== e.servo_index) begin
                $error("servo_index: expected %0d, got %0d", e.servo_index, word[4:2]);
                failures++;
            end
            if (word[8:5] !== e.pwm_channel) begin
                $error("pwm_channel: expected %0d, got %0d", e.pwm_channel, word[8:5]);
                failures++;
            end
            if (word[16:9] !== e.angle_value) begin
                $error("angle_value: expected %0d, got %0d", e.angle_value, word[16:9]);
                failures++;
            end
            if (word[25:17] !== e.off_count) begin
                $error("off_count: expected %0d, got %0d", e.off_count, word[25:17]);
                failures++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] status, [4:2] servo_index, [8:5] pwm_channel, [16:9] angle_value,
    // [25:17] off_count, [31:26] zero
    logic [TDATA_WIDTH-1:0] m_axis_tdata;

    servo_decode_scoreboard decoder_sb = new();
    int                     idle_pct = 0;
    int                     stall_pct = 0;
    int                     words_sent = 0;
    int                     cycle_count = 0;

    serial_servo_command_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls at random, changes at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // result words are taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            decoder_sb.check_word(m_axis_tdata);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // offer one byte, called just after a falling edge
    task automatic send_byte(input logic [7:0] rx);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!s_axis_tready);
        decoder_sb.note_byte(rx);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    // up to six digits, possibly none, followed by a servo letter or a sequence request, sometimes noisy
    task automatic send_command();
        int ndig;
        ndig = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(0, 6);
        for (int i = 0; i < ndig; i++) begin
            if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)));
            send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) < 8) send_byte(8'(CHAR_A + $urandom_range(0, 5)));
        else send_byte(CHAR_SEQ);
    endtask

    // hold off the sender until every result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (decoder_sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int phase_end;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes of the byte, clamping, wrap of the number, bad bytes,
        // bytes just outside the digit and letter ranges
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("180b");
        send_text("999c");
        send_text("65536d");
        send_text("1G2e");
        send_text("7g");
        send_text("/:`h");
        send_text("f");
        drain();

        // no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 17 : 0;
            stall_pct = (phase == 2) ? 51 : (phase == 3) ? 17 : 0;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
                else send_command();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoder_sb.failures == 0 && decoder_sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
